// ----- rtl/kvt_pkg.sv -----
// kvt_pkg: shared constants, opcodes and the cell control struct
// for the key-value table. No dependencies.
package kvt_pkg;

  localparam int TABLE_DEPTH_DEF = 128;
  localparam int KEY_BITS_DEF    = 32;
  localparam int VALUE_BITS_DEF  = 32;

  localparam int OP_W      = 2;
  localparam int KEY_FLD_W = 32;
  localparam int VAL_FLD_W = 32;
  localparam int POS_FLD_W = 7;
  localparam int CNT_FLD_W = 8;

  localparam logic [OP_W-1:0] OP_SET    = 2'd0;
  localparam logic [OP_W-1:0] OP_GET    = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  // cells reduced per scan cycle
  localparam int SCAN_GRP      = 16;
  localparam int SCAN_GRP_BITS = 4;

  typedef struct packed {
    logic cmp;
    logic wr_key;
    logic wr_val;
    logic shift;
  } kvt_ctl_t;

endpackage

// ----- rtl/kvt_if.sv -----
// kvt_req_if / kvt_rsp_if: valid-ready channels carrying the request
// and result words. Depends on kvt_pkg.
interface kvt_req_if;
  import kvt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      opcode;
  logic [KEY_FLD_W-1:0] lookup_key;
  logic [VAL_FLD_W-1:0] write_value;
  modport source(output valid, opcode, lookup_key, write_value, input ready);
  modport sink(input valid, opcode, lookup_key, write_value, output ready);
endinterface

interface kvt_rsp_if;
  import kvt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [VAL_FLD_W-1:0] read_value;
  logic [POS_FLD_W-1:0] match_position;
  logic [CNT_FLD_W-1:0] entry_count;
  logic                 full_reject;
  modport source(output valid, hit, read_value, match_position, entry_count, full_reject,
                 input ready);
  modport sink(input valid, hit, read_value, match_position, entry_count, full_reject,
               output ready);
endinterface

// ----- rtl/kvt_cell.sv -----
// kvt_cell: one table entry with its key compare, write port and
// shift-down path from its upper neighbor. Depends on kvt_pkg.
module kvt_cell #(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32,
  parameter int CELL_IDX   = 0,
  parameter int IDX_W      = 7,
  parameter int CNT_W      = 8
) (
  input  logic                  clk,
  input  kvt_pkg::kvt_ctl_t     ctl,
  input  logic [IDX_W-1:0]      wr_pos,
  input  logic [CNT_W-1:0]      count,
  input  logic [KEY_BITS-1:0]   key_in,
  input  logic [VALUE_BITS-1:0] val_in,
  input  logic [KEY_BITS-1:0]   nb_key,
  input  logic [VALUE_BITS-1:0] nb_val,
  output logic [KEY_BITS-1:0]   key_r,
  output logic [VALUE_BITS-1:0] val_r,
  output logic                  match_r
);
  import kvt_pkg::*;

  logic in_use;
  logic at_pos;
  logic above_pos;

  assign in_use    = CNT_W'(CELL_IDX) < count;
  assign at_pos    = wr_pos == IDX_W'(CELL_IDX);
  assign above_pos = IDX_W'(CELL_IDX) >= wr_pos;

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      match_r <= in_use && (key_r == key_in);
    end
    if (ctl.shift && above_pos) begin
      key_r <= nb_key;
      val_r <= nb_val;
    end else begin
      if (ctl.wr_key && at_pos) begin
        key_r <= key_in;
      end
      if (ctl.wr_val && at_pos) begin
        val_r <= val_in;
      end
    end
  end

endmodule

// ----- rtl/key_value_table_linear.sv -----
// Key-value table in insertion order, built as a row of entry cells that compare all keys at
// once and shift down on delete. An accepted word passes through a compare state, a match scan
// that folds 16 cell match flags per cycle, then the update, which loads the result word once
// the output register is empty or being taken. The result waits in the output register until
// taken; the next word is accepted from the cycle after the result is loaded, so the table
// takes no new word while one is in progress. Set updates a present key or appends; an append
// into a full table returns full_reject. Delete closes the gap. Clear empties it. Depends on
// kvt_pkg, kvt_if and kvt_cell.
module key_value_table_linear #(
  parameter int TABLE_DEPTH = kvt_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_BITS    = kvt_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS  = kvt_pkg::VALUE_BITS_DEF
) (
  input logic     clk,
  input logic     rst_n,
  kvt_req_if.sink   in_req,
  kvt_rsp_if.source out_rsp
);
  import kvt_pkg::*;

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int NGRP   = (TABLE_DEPTH + SCAN_GRP - 1) / SCAN_GRP;
  localparam int GRP_W  = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int FLAT_W = GRP_W + SCAN_GRP_BITS + 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CMP   = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_APPLY = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [OP_W-1:0]       op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [GRP_W-1:0]      grp_r;
  logic                  hit_r;
  logic [IDX_W-1:0]      pos_r;
  logic [VALUE_BITS-1:0] rval_r;

  logic                  out_valid_r;
  logic                  out_hit_r, out_full_r;
  logic [VALUE_BITS-1:0] out_val_r;
  logic [IDX_W-1:0]      out_pos_r;
  logic [CNT_W-1:0]      out_cnt_r;

  logic [KEY_BITS-1:0]   cell_key   [TABLE_DEPTH];
  logic [VALUE_BITS-1:0] cell_val   [TABLE_DEPTH];
  logic                  cell_match [TABLE_DEPTH];

  kvt_ctl_t              ctl;
  logic [IDX_W-1:0]      wr_pos;
  logic                  in_fire, apply_fire;
  logic                  res_hit, res_full;
  logic [VALUE_BITS-1:0] res_val;
  logic [IDX_W-1:0]      res_pos;

  logic                  g_hit;
  logic [IDX_W-1:0]      g_pos;
  logic [VALUE_BITS-1:0] g_val;

  assign in_req.ready = (state_r == ST_IDLE);
  assign in_fire      = in_req.valid && in_req.ready;
  assign apply_fire   = (state_r == ST_APPLY) && (!out_valid_r || out_rsp.ready);

  // entry cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [KEY_BITS-1:0]   nb_key;
    logic [VALUE_BITS-1:0] nb_val;
    if (i < TABLE_DEPTH - 1) begin : g_nb
      assign nb_key = cell_key[i+1];
      assign nb_val = cell_val[i+1];
    end else begin : g_last
      assign nb_key = '0;
      assign nb_val = '0;
    end
    kvt_cell #(
      .KEY_BITS  (KEY_BITS),
      .VALUE_BITS(VALUE_BITS),
      .CELL_IDX  (i),
      .IDX_W     (IDX_W),
      .CNT_W     (CNT_W)
    ) u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .wr_pos (wr_pos),
      .count  (count_r),
      .key_in (key_r),
      .val_in (val_r),
      .nb_key (nb_key),
      .nb_val (nb_val),
      .key_r  (cell_key[i]),
      .val_r  (cell_val[i]),
      .match_r(cell_match[i])
    );
  end

  // fold one group of match flags
  always_comb begin
    logic [FLAT_W-1:0] flat;
    logic              m;
    g_hit = 1'b0;
    g_pos = '0;
    g_val = '0;
    for (int i = 0; i < SCAN_GRP; i++) begin
      flat = {1'b0, grp_r, SCAN_GRP_BITS'(i)};
      m    = 1'b0;
      if (flat < FLAT_W'(TABLE_DEPTH)) begin
        m = cell_match[flat[IDX_W-1:0]];
      end
      if (m) begin
        g_hit = 1'b1;
        g_pos = g_pos | flat[IDX_W-1:0];
        g_val = g_val | cell_val[flat[IDX_W-1:0]];
      end
    end
  end

  // result and cell commands
  always_comb begin
    ctl       = '0;
    ctl.cmp   = (state_r == ST_CMP);
    wr_pos    = pos_r;
    count_nxt = count_r;
    res_hit   = 1'b0;
    res_full  = 1'b0;
    res_val   = '0;
    res_pos   = '0;
    case (op_r)
      OP_SET: begin
        if (hit_r) begin
          ctl.wr_val = apply_fire;
          res_hit    = 1'b1;
          res_pos    = pos_r;
        end else if (count_r < CNT_W'(TABLE_DEPTH)) begin
          ctl.wr_key = apply_fire;
          ctl.wr_val = apply_fire;
          wr_pos     = count_r[IDX_W-1:0];
          res_pos    = count_r[IDX_W-1:0];
          count_nxt  = count_r + CNT_W'(1);
        end else begin
          res_full = 1'b1;
        end
      end
      OP_GET: begin
        if (hit_r) begin
          res_hit = 1'b1;
          res_val = rval_r;
          res_pos = pos_r;
        end
      end
      OP_DELETE: begin
        if (hit_r) begin
          ctl.shift = apply_fire;
          res_hit   = 1'b1;
          res_pos   = pos_r;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: begin
        count_nxt = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_fire) state_nxt = ST_CMP;
      ST_CMP:   state_nxt = ST_SCAN;
      ST_SCAN:  if (grp_r == GRP_W'(NGRP - 1)) state_nxt = ST_APPLY;
      ST_APPLY: if (apply_fire) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (apply_fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_req.opcode;
      key_r <= KEY_BITS'(in_req.lookup_key);
      val_r <= VALUE_BITS'(in_req.write_value);
    end
    if (state_r == ST_CMP) begin
      grp_r  <= '0;
      hit_r  <= 1'b0;
      pos_r  <= '0;
      rval_r <= '0;
    end else if (state_r == ST_SCAN) begin
      grp_r  <= grp_r + GRP_W'(1);
      hit_r  <= hit_r | g_hit;
      pos_r  <= pos_r | g_pos;
      rval_r <= rval_r | g_val;
    end
    if (apply_fire) begin
      out_hit_r  <= res_hit;
      out_full_r <= res_full;
      out_val_r  <= res_val;
      out_pos_r  <= res_pos;
      out_cnt_r  <= count_nxt;
    end
  end

  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.hit            = out_hit_r;
  assign out_rsp.full_reject    = out_full_r;
  assign out_rsp.read_value     = VAL_FLD_W'(out_val_r);
  assign out_rsp.match_position = POS_FLD_W'(out_pos_r);
  assign out_rsp.entry_count    = CNT_FLD_W'(out_cnt_r);

endmodule

// ----- tb/sv/key_value_table_linear_test.sv -----
`timescale 1ns / 1ps
// key_value_table_linear_test: self-checking bench for the insertion-ordered key-value table,
// with a shadow table that predicts every result word, random idling on both channels.
// Depends on kvt_pkg, kvt_if and the key_value_table_linear rtl.
module key_value_table_linear_test;
  import kvt_pkg::*;

  localparam int DEPTH       = TABLE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 40;

  typedef struct packed {
    logic                 hit;
    logic [VAL_FLD_W-1:0] read_value;
    logic [POS_FLD_W-1:0] match_position;
    logic [CNT_FLD_W-1:0] entry_count;
    logic                 full_reject;
  } table_result_t;

  class table_scoreboard;
    logic [KEY_FLD_W-1:0] shadow_keys[DEPTH];
    logic [VAL_FLD_W-1:0] shadow_values[DEPTH];
    int                   shadow_count;
    table_result_t        pending_results[$];
    int                   op_totals[4];
    int                   hits;
    int                   rejects;
    int                   checked;
    int                   errors;

    function new();
      shadow_count = 0;
      hits         = 0;
      rejects      = 0;
      checked      = 0;
      errors       = 0;
      foreach (op_totals[i]) op_totals[i] = 0;
    endfunction

    function logic [KEY_FLD_W-1:0] key_at(int idx);
      return shadow_keys[idx];
    endfunction

    function logic [KEY_FLD_W-1:0] present_key();
      return shadow_keys[$urandom_range(0, shadow_count - 1)];
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [KEY_FLD_W-1:0] key,
                               logic [VAL_FLD_W-1:0] val);
      table_result_t exp;
      int            found;
      exp   = '0;
      found = -1;
      op_totals[op]++;
      for (int i = 0; i < shadow_count && found < 0; i++)
        if (shadow_keys[i] == key) found = i;
      case (op)
        OP_SET: begin
          if (found >= 0) begin
            shadow_values[found] = val;
            exp.hit = 1'b1;
            exp.match_position = POS_FLD_W'(found);
          end else if (shadow_count < DEPTH) begin
            shadow_keys[shadow_count]   = key;
            shadow_values[shadow_count] = val;
            exp.match_position = POS_FLD_W'(shadow_count);
            shadow_count++;
          end else begin
            exp.full_reject = 1'b1;
          end
        end
        OP_GET: begin
          if (found >= 0) begin
            exp.hit = 1'b1;
            exp.read_value = shadow_values[found];
            exp.match_position = POS_FLD_W'(found);
          end
        end
        OP_DELETE: begin
          if (found >= 0) begin
            for (int j = found; j + 1 < shadow_count; j++) begin
              shadow_keys[j]   = shadow_keys[j + 1];
              shadow_values[j] = shadow_values[j + 1];
            end
            shadow_count--;
            exp.hit = 1'b1;
            exp.match_position = POS_FLD_W'(found);
          end
        end
        default: shadow_count = 0;
      endcase
      exp.entry_count = CNT_FLD_W'(shadow_count);
      if (exp.hit) hits++;
      if (exp.full_reject) rejects++;
      pending_results.push_back(exp);
    endfunction

    function void check_result(table_result_t got);
      table_result_t exp;
      if (pending_results.size() == 0) begin
        $error("result word with no request pending");
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      checked++;
      if (got.hit !== exp.hit) begin
        $error("hit: expected %0d, got %0d", exp.hit, got.hit);
        errors++;
      end
      if (got.read_value !== exp.read_value) begin
        $error("read_value: expected %h, got %h", exp.read_value, got.read_value);
        errors++;
      end
      if (got.match_position !== exp.match_position) begin
        $error("match_position: expected %0d, got %0d", exp.match_position,
               got.match_position);
        errors++;
      end
      if (got.entry_count !== exp.entry_count) begin
        $error("entry_count: expected %0d, got %0d", exp.entry_count, got.entry_count);
        errors++;
      end
      if (got.full_reject !== exp.full_reject) begin
        $error("full_reject: expected %0d, got %0d", exp.full_reject, got.full_reject);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   cycle_count = 0;
  bit   sender_paced;
  bit   receiver_paced;

  logic [KEY_FLD_W-1:0] key_pool[16];
  table_scoreboard      sb;

  kvt_req_if in_req();
  kvt_rsp_if out_rsp();

  key_value_table_linear uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("key_value_table_linear regression: fail");
      $finish;
    end
  end

  // called at a clock edge; valid stays high across back-to-back words
  task automatic send_word(logic [OP_W-1:0] op, logic [KEY_FLD_W-1:0] key,
                           logic [VAL_FLD_W-1:0] val);
    int gap;
    if ($urandom_range(0, 29) == 0) sender_paced = !sender_paced;
    gap = sender_paced ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid       <= 1'b1;
    in_req.opcode      <= op;
    in_req.lookup_key  <= key;
    in_req.write_value <= val;
    do @(posedge clk); while (!in_req.ready);
    sb.note_request(op, key, val);
  endtask

  task automatic run_mixed(int count);
    int                   r;
    logic [OP_W-1:0]      op;
    logic [KEY_FLD_W-1:0] key;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 40) op = OP_SET;
      else if (r < 70) op = OP_GET;
      else if (r < 97) op = OP_DELETE;
      else op = OP_CLEAR;
      r = $urandom_range(0, 9);
      if (r < 4) key = key_pool[$urandom_range(0, 15)];
      else if (r < 8 && sb.shadow_count > 0) key = sb.present_key();
      else key = $urandom;
      send_word(op, key, $urandom);
    end
  endtask

  // fresh keys until the table is full, then a few appends that must bounce
  task automatic fill_table();
    while (sb.shadow_count < DEPTH) send_word(OP_SET, $urandom, $urandom);
    repeat (3) send_word(OP_SET, $urandom, $urandom);
  endtask

  initial begin
    out_rsp.ready <= 1'b0;
    receiver_paced = 1'b1;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      int            stall;
      table_result_t got;
      if ($urandom_range(0, 29) == 0) receiver_paced = !receiver_paced;
      stall = receiver_paced ? $urandom_range(0, 14) : 0;
      if (stall > 0) begin
        out_rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_rsp.ready <= 1'b1;
      do @(posedge clk); while (!out_rsp.valid);
      got.hit            = out_rsp.hit;
      got.read_value     = out_rsp.read_value;
      got.match_position = out_rsp.match_position;
      got.entry_count    = out_rsp.entry_count;
      got.full_reject    = out_rsp.full_reject;
      sb.check_result(got);
    end
  end

  initial begin
    logic [KEY_FLD_W-1:0] key_a;
    logic [KEY_FLD_W-1:0] key_b;
    sb = new();
    sender_paced = 1'b1;
    rst_n <= 1'b0;
    in_req.valid       <= 1'b0;
    in_req.opcode      <= OP_SET;
    in_req.lookup_key  <= '0;
    in_req.write_value <= '0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 16; i++) key_pool[i] = $urandom;
    key_a = 32'h5a5a_0001;
    key_b = 32'ha5a5_0002;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, extreme keys and values, update, deletes at each end and the middle
    send_word(OP_GET, '0, '1);
    send_word(OP_DELETE, '0, '0);
    send_word(OP_SET, '0, '1);
    send_word(OP_SET, '1, '0);
    send_word(OP_SET, key_a, $urandom);
    send_word(OP_SET, key_b, $urandom);
    send_word(OP_GET, '0, $urandom);
    send_word(OP_GET, '1, $urandom);
    send_word(OP_SET, '0, 32'h1234_5678);
    send_word(OP_GET, '0, '0);
    send_word(OP_DELETE, '1, '1);
    send_word(OP_GET, key_b, '0);
    send_word(OP_DELETE, key_b, '0);
    send_word(OP_DELETE, '0, '0);
    send_word(OP_GET, key_a, '0);
    send_word(OP_GET, key_b, '0);
    send_word(OP_DELETE, key_b, '0);
    send_word(OP_CLEAR, $urandom, $urandom);
    send_word(OP_GET, key_a, '0);
    send_word(OP_SET, key_a, $urandom);
    send_word(OP_CLEAR, '1, '1);

    run_mixed(180);
    fill_table();
    send_word(OP_SET, sb.present_key(), $urandom);
    repeat (3) send_word(OP_GET, sb.present_key(), $urandom);
    send_word(OP_DELETE, sb.present_key(), $urandom);
    send_word(OP_SET, $urandom, $urandom);
    send_word(OP_SET, $urandom, $urandom);
    send_word(OP_GET, $urandom, $urandom);
    send_word(OP_DELETE, sb.key_at(DEPTH - 2), $urandom);
    send_word(OP_DELETE, sb.key_at(0), $urandom);
    run_mixed(60);
    send_word(OP_CLEAR, $urandom, $urandom);
    run_mixed(100);

    in_req.valid <= 1'b0;
    while (sb.pending_results.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d words: %0d set, %0d get, %0d delete, %0d clear, full table reached",
             sb.checked, sb.op_totals[OP_SET], sb.op_totals[OP_GET],
             sb.op_totals[OP_DELETE], sb.op_totals[OP_CLEAR]);
    $display("%0d hits, %0d full-table rejects, %0d mismatches",
             sb.hits, sb.rejects, sb.errors);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("key_value_table_linear regression: pass");
    end else begin
      $display("key_value_table_linear regression: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/kvt_pkg.sv
rtl/kvt_if.sv
rtl/kvt_cell.sv
rtl/key_value_table_linear.sv
tb/sv/key_value_table_linear_test.sv
